/* rtl/dtt_pkg.sv */
// ----------------------------------------------------------------------------
// dtt_pkg
// Shared constants, command codes, sequencer states and result word type
// of the delay timer table.
// ----------------------------------------------------------------------------
package dtt_pkg;

    localparam int TABLE_DEPTH  = 16;
    localparam int KEY_BITS     = 16;
    localparam int IDX_BITS     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_BITS     = IDX_BITS + 1;
    localparam int TIME_BITS    = 48;
    localparam int DELAY_BITS   = 40;
    localparam int IN_KEY_BITS  = 16;
    localparam int OUT_KEY_BITS = 16;
    localparam int ENTRY_BITS   = KEY_BITS + TIME_BITS;
    localparam int KIND_BITS    = 3;
    localparam int IN_DATA_BITS = IN_KEY_BITS + DELAY_BITS + TIME_BITS;
    localparam int OUT_USER_BITS = 2;

    typedef enum logic [KIND_BITS-1:0] {
        K_ADD    = 3'd0,
        K_UPDATE = 3'd1,
        K_CANCEL = 3'd2,
        K_SCAN   = 3'd3,
        K_CLEAR  = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic                    status;
        logic                    fired_valid;
        logic [OUT_KEY_BITS-1:0] fired_key;
        logic                    last;
    } t_result;

endpackage

/* rtl/dtt_ram.sv */
// ----------------------------------------------------------------------------
// dtt_ram
// Single write port, single read port RAM with registered read data.
// Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module dtt_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/dtt_out.sv */
// ----------------------------------------------------------------------------
// dtt_out
// Output register of the result stream. Takes one result word when empty
// or when the held word leaves in the same cycle.
// ----------------------------------------------------------------------------
module dtt_out (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  dtt_pkg::t_result                    i_res,
    output logic                                o_ready,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // fired_key
    output logic [dtt_pkg::OUT_KEY_BITS-1:0]    o_m_axis_tdata,
    // status, fired_valid
    output logic [dtt_pkg::OUT_USER_BITS-1:0]   o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);

    import dtt_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    always_comb begin
        o_ready = !r_valid || i_m_axis_tready;
        n_valid = r_valid;
        if (i_push) begin
            n_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_res <= i_res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_res.fired_key;
    assign o_m_axis_tuser  = {r_res.fired_valid, r_res.status};
    assign o_m_axis_tlast  = r_res.last;

endmodule

/* rtl/delay_timer_table.sv */
// ----------------------------------------------------------------------------
// delay_timer_table
// Table of one-shot delay timers keyed by task id. Keys and deadlines live
// in a RAM, used and cancel flags in flip-flops.
// Flow: add, clear and unknown kinds go from accept straight to the finish
// state, which pushes once the output register has room. Update, cancel
// and scan first sweep every slot through the RAM read port; stalls pause it.
// Throughput: one word at a time; a new word is taken once the last result
// is in the output register.
// Reset: synchronous, active low; empties the table at once, no clearing pass.
// ----------------------------------------------------------------------------
module delay_timer_table (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // task_key, delay_us, now_us
    input  logic [dtt_pkg::IN_DATA_BITS-1:0]    i_s_axis_tdata,
    // kind
    input  logic [dtt_pkg::KIND_BITS-1:0]       i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // fired_key
    output logic [dtt_pkg::OUT_KEY_BITS-1:0]    o_m_axis_tdata,
    // status, fired_valid
    output logic [dtt_pkg::OUT_USER_BITS-1:0]   o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);

    import dtt_pkg::*;

    localparam logic [CNT_BITS-1:0] SWEEP_END = CNT_BITS'(TABLE_DEPTH);

    t_state                 r_state,      n_state;
    t_kind                  r_kind,       n_kind;
    logic [KEY_BITS-1:0]    r_key,        n_key;
    logic [TIME_BITS-1:0]   r_deadline,   n_deadline;
    logic [TIME_BITS-1:0]   r_now,        n_now;
    logic [TABLE_DEPTH-1:0] r_used,       n_used;
    logic [TABLE_DEPTH-1:0] r_canc,       n_canc;
    logic [CNT_BITS-1:0]    r_raddr,      n_raddr;
    logic                   r_pvalid,     n_pvalid;
    logic [IDX_BITS-1:0]    r_pidx,       n_pidx;
    logic                   r_found,      n_found;
    logic [IDX_BITS-1:0]    r_fidx,       n_fidx;
    logic                   r_hold_valid, n_hold_valid;
    logic [KEY_BITS-1:0]    r_hold_key,   n_hold_key;

    logic                   s_acc;
    logic [TIME_BITS:0]     sum;
    logic [TIME_BITS-1:0]   in_now;
    logic                   rd_en;
    logic                   wr_en;
    logic [IDX_BITS-1:0]    wr_addr;
    logic [ENTRY_BITS-1:0]  wr_data;
    logic [ENTRY_BITS-1:0]  rd_data;
    logic [KEY_BITS-1:0]    rd_key;
    logic [TIME_BITS-1:0]   rd_deadline;
    logic                   match;
    logic                   fire;
    logic                   stall;
    logic                   free_found;
    logic [IDX_BITS-1:0]    free_idx;
    logic                   add_status;
    logic                   push;
    t_result                push_res;
    logic                   out_ready;

    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign in_now          = i_s_axis_tdata[IN_DATA_BITS-1 -: TIME_BITS];
    assign sum             = {1'b0, in_now}
                           + (TIME_BITS+1)'(i_s_axis_tdata[IN_KEY_BITS +: DELAY_BITS]);
    assign rd_key          = rd_data[ENTRY_BITS-1 -: KEY_BITS];
    assign rd_deadline     = rd_data[TIME_BITS-1:0];

    assign match = (r_kind == K_UPDATE || r_kind == K_CANCEL) && r_used[r_pidx]
                && !r_canc[r_pidx] && (rd_key == r_key);
    assign fire  = (r_kind == K_SCAN) && r_used[r_pidx] && (rd_deadline < r_now);
    assign stall = r_pvalid && fire && r_hold_valid && !out_ready;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_BITS'(i);
            end
        end
    end

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_key        = r_key;
        n_deadline   = r_deadline;
        n_now        = r_now;
        n_used       = r_used;
        n_canc       = r_canc;
        n_raddr      = r_raddr;
        n_pvalid     = r_pvalid;
        n_pidx       = r_pidx;
        n_found      = r_found;
        n_fidx       = r_fidx;
        n_hold_valid = r_hold_valid;
        n_hold_key   = r_hold_key;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = free_idx;
        wr_data      = {r_key, r_deadline};
        add_status   = 1'b0;
        push         = 1'b0;
        push_res     = '{status: 1'b0, fired_valid: 1'b0, fired_key: '0, last: 1'b1};

        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    n_kind       = t_kind'(i_s_axis_tuser);
                    n_key        = KEY_BITS'(i_s_axis_tdata[IN_KEY_BITS-1:0]);
                    n_deadline   = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
                    n_now        = in_now;
                    n_raddr      = '0;
                    n_pvalid     = 1'b0;
                    n_found      = 1'b0;
                    n_hold_valid = 1'b0;
                    if (n_kind == K_UPDATE || n_kind == K_CANCEL || n_kind == K_SCAN) begin
                        n_state = ST_SWEEP;
                    end else begin
                        n_state = ST_FINISH;
                    end
                    if (n_kind == K_SCAN) begin
                        n_used = r_used & ~r_canc;
                        n_canc = '0;
                    end
                end
            end
            ST_SWEEP: begin
                if (!stall) begin
                    if (r_pvalid) begin
                        if (match && !r_found) begin
                            n_found = 1'b1;
                            n_fidx  = r_pidx;
                        end
                        if (fire) begin
                            n_used[r_pidx] = 1'b0;
                            n_hold_valid   = 1'b1;
                            n_hold_key     = rd_key;
                            if (r_hold_valid) begin
                                push     = 1'b1;
                                push_res = '{status: 1'b0, fired_valid: 1'b1,
                                             fired_key: OUT_KEY_BITS'(r_hold_key),
                                             last: 1'b0};
                            end
                        end
                    end
                    if (r_raddr != SWEEP_END) begin
                        rd_en    = 1'b1;
                        n_raddr  = r_raddr + CNT_BITS'(1);
                        n_pvalid = 1'b1;
                        n_pidx   = r_raddr[IDX_BITS-1:0];
                    end else begin
                        n_pvalid = 1'b0;
                        n_state  = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (out_ready) begin
                    push    = 1'b1;
                    n_state = ST_IDLE;
                    unique case (r_kind)
                        K_ADD: begin
                            if (free_found) begin
                                wr_en            = 1'b1;
                                n_used[free_idx] = 1'b1;
                                n_canc[free_idx] = 1'b0;
                            end else begin
                                add_status = 1'b1;
                            end
                        end
                        K_UPDATE: begin
                            if (r_found) begin
                                wr_en   = 1'b1;
                                wr_addr = r_fidx;
                            end else if (free_found) begin
                                wr_en            = 1'b1;
                                n_used[free_idx] = 1'b1;
                                n_canc[free_idx] = 1'b0;
                            end else begin
                                add_status = 1'b1;
                            end
                        end
                        K_CANCEL: begin
                            if (r_found) begin
                                n_canc[r_fidx] = 1'b1;
                            end
                        end
                        K_SCAN: begin
                            if (r_hold_valid) begin
                                push_res.fired_valid = 1'b1;
                                push_res.fired_key   = OUT_KEY_BITS'(r_hold_key);
                            end
                        end
                        K_CLEAR: begin
                            n_used = '0;
                            n_canc = '0;
                        end
                        default: begin
                        end
                    endcase
                    push_res.status = add_status;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_used       <= '0;
            r_canc       <= '0;
            r_pvalid     <= 1'b0;
            r_found      <= 1'b0;
            r_hold_valid <= 1'b0;
            r_raddr      <= '0;
        end else begin
            r_state      <= n_state;
            r_used       <= n_used;
            r_canc       <= n_canc;
            r_pvalid     <= n_pvalid;
            r_found      <= n_found;
            r_hold_valid <= n_hold_valid;
            r_raddr      <= n_raddr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_key      <= n_key;
        r_deadline <= n_deadline;
        r_now      <= n_now;
        r_pidx     <= n_pidx;
        r_fidx     <= n_fidx;
        r_hold_key <= n_hold_key;
    end

    dtt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_BITS),
        .AW    (IDX_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_raddr[IDX_BITS-1:0]),
        .o_rd_data (rd_data)
    );

    dtt_out u_out (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_res           (push_res),
        .o_ready         (out_ready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    a_canc_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_canc & ~r_used) == '0)
        else $error("cancel flag set on a free slot");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> out_ready)
        else $error("result word pushed into a full output register");

    a_found_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP && r_found) |-> r_used[r_fidx])
        else $error("matched slot is not in use");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> (r_state != ST_IDLE))
        else $error("sequencer stayed idle after accepting a word");

    a_sweep_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP && r_raddr == SWEEP_END) |-> !rd_en)
        else $error("RAM read issued past the last slot");

endmodule
